// ===== rtl/servo_command_map_velocity_macros.svh =====
// Assertion macros for the servo command path.
// Used by scmv_mdu and servo_command_map_velocity; expects i_clk and i_rst_n in scope.
`ifndef SERVO_COMMAND_MAP_VELOCITY_MACROS_SVH
`define SERVO_COMMAND_MAP_VELOCITY_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SCMV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SCMV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/scmv_pkg.sv =====
// Shared types, constants and helper functions of the servo command path.
// No dependencies; imported by scmv_mdu and servo_command_map_velocity.
`default_nettype none

package scmv_pkg;

    localparam int POS_W   = 16;
    localparam int DT_W    = 16;
    localparam int PULSE_W = 12;
    localparam int VEL_W   = 32;
    localparam int DIFF_W  = POS_W + 1;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_ADDR_W-1:0] CFG_CALIB_ENABLE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT_LOW    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT_HIGH   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_MIN    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_MAX    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_SERVO_MIN    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_SERVO_MAX    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_VEL_ALPHA    = 3'd7;

    localparam int ALPHA_FRAC = 16;
    localparam logic [CFG_DATA_W-1:0] ALPHA_ONE   = 17'h10000;
    localparam logic [CFG_DATA_W-1:0] ALPHA_RESET = 17'd6554;

    localparam int TARGET_RESET_WHOLE = 1500;
    localparam int POS_MAX            = 32767;
    localparam int RATE_SCALE         = 1000000;

    // Shared multiply/divide unit: multiplicand or dividend, multiplier or divisor, product.
    localparam int MDU_AW    = 40;
    localparam int MDU_BW    = 17;
    localparam int MDU_PW    = MDU_AW + MDU_BW;
    localparam int MDU_CNT_W = $clog2(MDU_AW + 1);

    // Mapped pulse value before the shift: quotient plus servo_min.
    localparam int VAL_W = 35;

    typedef enum logic {
        MDU_MUL,
        MDU_DIV
    } t_mdu_op;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mdu_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLAMP,
        S_MAP_MUL,
        S_MAP_DIV,
        S_PULSE,
        S_RATE_MUL,
        S_RATE_DIV,
        S_VEL_NEW,
        S_VEL_OLD,
        S_SUM,
        S_SCALE,
        S_DONE
    } t_state;

    function automatic logic signed [DIFF_W-1:0] sdiff17(input logic signed [POS_W-1:0] a,
                                                         input logic signed [POS_W-1:0] b);
        return {a[POS_W-1], a} - {b[POS_W-1], b};
    endfunction

    function automatic logic [DIFF_W-1:0] mag17(input logic signed [DIFF_W-1:0] x);
        return x[DIFF_W-1] ? DIFF_W'(-x) : DIFF_W'(x);
    endfunction

    function automatic logic [VEL_W-1:0] mag32(input logic signed [VEL_W-1:0] x);
        return x[VEL_W-1] ? VEL_W'(-x) : VEL_W'(x);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/scmv_mdu.sv =====
// Shared unsigned multiply/divide unit, one bit per cycle.
// Shift-add multiply and restoring divide; depends on scmv_pkg.
`default_nettype none
`include "servo_command_map_velocity_macros.svh"

module scmv_mdu (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  scmv_pkg::t_mdu_ctrl            i_ctrl,
    input  logic [scmv_pkg::MDU_AW-1:0]    i_a,
    input  logic [scmv_pkg::MDU_BW-1:0]    i_b,
    output scmv_pkg::t_mdu_stat            o_stat,
    output logic [scmv_pkg::MDU_PW-1:0]    o_result
);
    import scmv_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MDU_CNT_W-1:0] r_cnt;
    t_mdu_op              r_op;
    logic [MDU_PW-1:0]    r_acc;
    logic [MDU_PW-1:0]    r_sh;
    logic [MDU_BW-1:0]    r_b;
    logic [MDU_BW-1:0]    r_rem;

    logic [MDU_BW:0]      w_trial;
    logic [MDU_BW:0]      w_sub;
    logic                 w_fits;
    logic                 w_last;

    assign w_trial = {r_rem, r_acc[MDU_AW-1]};
    assign w_sub   = w_trial - {1'b0, r_b};
    assign w_fits  = (w_trial >= {1'b0, r_b});
    assign w_last  = (r_op == MDU_MUL) ? (r_cnt == MDU_CNT_W'(MDU_BW - 1))
                                       : (r_cnt == MDU_CNT_W'(MDU_AW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_op  <= i_ctrl.op;
            r_acc <= (i_ctrl.op == MDU_MUL) ? '0 : MDU_PW'(i_a);
            r_sh  <= MDU_PW'(i_a);
            r_b   <= i_b;
            r_rem <= '0;
        end else if (r_busy) begin
            unique case (r_op)
                MDU_MUL: begin
                    if (r_b[0]) begin
                        r_acc <= r_acc + r_sh;
                    end
                    r_sh <= r_sh << 1;
                    r_b  <= r_b >> 1;
                end
                MDU_DIV: begin
                    r_acc[MDU_AW-1:0] <= {r_acc[MDU_AW-2:0], w_fits};
                    r_rem <= w_fits ? w_sub[MDU_BW-1:0] : w_trial[MDU_BW-1:0];
                end
            endcase
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_acc;

    `SCMV_ASSERT_SAME(a_mdu_start_idle, i_ctrl.start, !r_busy && !r_done, "mdu started while busy")
    `SCMV_ASSERT_NEXT(a_mdu_start_busy, i_ctrl.start, r_busy && !r_done, "mdu did not start")
    `SCMV_ASSERT_SAME(a_mdu_done_idle, r_done, !r_busy, "mdu done while busy")

endmodule

`default_nettype wire

// ===== rtl/servo_command_map_velocity.sv =====
// Servo command path: target clamp, linear pulse-width map, IIR velocity estimate.
// Top level; depends on scmv_pkg and scmv_mdu.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+----------------------------------------
//  in       | i_in_valid   | o_in_stall   | i_op, i_target_pos, i_tick_dt
//  out      | o_out_valid  | i_out_stall  | o_pulse_us, o_position, o_velocity
//  cfg      | i_cfg_we     | -            | i_cfg_addr, i_cfg_wdata
//
// A set-target transfer updates the stored target and gives no result.
// A tick runs the rate and velocity steps on the shared multiply/divide unit, and the
// map multiply and divide first when the linear map is enabled and the angle range is
// nonzero; the unit works one bit per cycle.
// o_in_stall is high while a tick is in work; a tick finished while the output register
// is still full holds in its last step until the output transfer.
// Synchronous active-low reset; no clearing pass.
`default_nettype none
`include "servo_command_map_velocity_macros.svh"

module servo_command_map_velocity #(
    parameter int POS_FRAC_BITS = 4,
    parameter int PULSE_MAX     = 4095
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [scmv_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [scmv_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_op,
    input  logic signed [scmv_pkg::POS_W-1:0]    i_target_pos,
    input  logic [scmv_pkg::DT_W-1:0]            i_tick_dt,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [scmv_pkg::PULSE_W-1:0]         o_pulse_us,
    output logic signed [scmv_pkg::POS_W-1:0]    o_position,
    output logic signed [scmv_pkg::VEL_W-1:0]    o_velocity
);
    import scmv_pkg::*;

    localparam int TARGET_FULL = TARGET_RESET_WHOLE * (1 << POS_FRAC_BITS);
    localparam logic signed [POS_W-1:0] TARGET_RESET =
        (TARGET_FULL > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(TARGET_FULL);
    localparam logic signed [MDU_PW-1:0] VEL_BIAS = MDU_PW'((1 << ALPHA_FRAC) - 1);

    // configuration
    logic                     r_calib_en;
    logic signed [POS_W-1:0]  r_limit_low;
    logic signed [POS_W-1:0]  r_limit_high;
    logic signed [POS_W-1:0]  r_angle_min;
    logic signed [POS_W-1:0]  r_angle_max;
    logic signed [POS_W-1:0]  r_servo_min;
    logic signed [POS_W-1:0]  r_servo_max;
    logic [CFG_DATA_W-1:0]    r_vel_alpha;

    // sequencer and state
    t_state                   r_state;
    t_state                   n_state;
    logic                     r_issued;
    logic                     n_issued;
    logic signed [POS_W-1:0]  r_target;
    logic signed [POS_W-1:0]  r_last_pos;
    logic signed [VEL_W-1:0]  r_last_vel;
    logic [DT_W-1:0]          r_dt;
    logic signed [VAL_W-1:0]  r_val;
    logic [PULSE_W-1:0]       r_pulse;
    logic signed [MDU_PW-1:0] r_term_new;
    logic signed [MDU_PW-1:0] r_term_old;
    logic signed [MDU_PW-1:0] r_sum;
    logic signed [VEL_W-1:0]  r_vel;

    // output register
    logic                     r_out_valid;
    logic [PULSE_W-1:0]       r_out_pulse;
    logic signed [POS_W-1:0]  r_out_pos;
    logic signed [VEL_W-1:0]  r_out_vel;

    t_mdu_ctrl                w_mdu_ctrl;
    t_mdu_stat                w_mdu_stat;
    logic [MDU_AW-1:0]        w_mdu_a;
    logic [MDU_BW-1:0]        w_mdu_b;
    logic [MDU_PW-1:0]        w_mdu_res;

    logic                     w_in_fire;
    logic                     w_load;
    logic signed [POS_W-1:0]  w_clamped;
    logic signed [DIFF_W-1:0] w_num_a;
    logic signed [DIFF_W-1:0] w_num_b;
    logic signed [DIFF_W-1:0] w_den;
    logic signed [DIFF_W-1:0] w_diff;
    logic                     w_map_neg;
    logic [CFG_DATA_W-1:0]    w_alpha;
    logic [CFG_DATA_W-1:0]    w_alpha_old;
    logic signed [VAL_W-1:0]  w_q_mag;
    logic signed [VAL_W-1:0]  w_q;
    logic signed [VAL_W-1:0]  w_pulse_sh;
    logic signed [MDU_PW-1:0] w_prod;
    logic signed [MDU_PW-1:0] w_biased;
    logic signed [MDU_PW-1:0] w_shr;
    logic                     w_vel_fits;

    assign w_in_fire = i_in_valid && !o_in_stall;
    assign w_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign w_clamped = (r_target > r_limit_high) ? r_limit_high :
                       (r_target < r_limit_low)  ? r_limit_low  : r_target;
    assign w_num_a   = sdiff17(r_target, r_angle_min);
    assign w_num_b   = sdiff17(r_servo_max, r_servo_min);
    assign w_den     = sdiff17(r_angle_max, r_angle_min);
    assign w_diff    = sdiff17(r_target, r_last_pos);
    assign w_map_neg = w_num_a[DIFF_W-1] ^ w_num_b[DIFF_W-1] ^ w_den[DIFF_W-1];

    assign w_alpha     = (r_vel_alpha > ALPHA_ONE) ? ALPHA_ONE : r_vel_alpha;
    assign w_alpha_old = ALPHA_ONE - w_alpha;

    assign w_q_mag    = $signed(w_mdu_res[VAL_W-1:0]);
    assign w_q        = w_map_neg ? -w_q_mag : w_q_mag;
    assign w_pulse_sh = r_val >>> POS_FRAC_BITS;
    assign w_prod     = $signed(w_mdu_res);
    assign w_biased   = r_sum + (r_sum[MDU_PW-1] ? VEL_BIAS : '0);
    assign w_shr      = w_biased >>> ALPHA_FRAC;
    assign w_vel_fits = (w_shr[MDU_PW-1:VEL_W-1] == '0) || (w_shr[MDU_PW-1:VEL_W-1] == '1);

    scmv_mdu u_mdu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_mdu_ctrl),
        .i_a      (w_mdu_a),
        .i_b      (w_mdu_b),
        .o_stat   (w_mdu_stat),
        .o_result (w_mdu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_en   <= 1'b0;
            r_limit_low  <= '0;
            r_limit_high <= '0;
            r_angle_min  <= '0;
            r_angle_max  <= '0;
            r_servo_min  <= '0;
            r_servo_max  <= '0;
            r_vel_alpha  <= ALPHA_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CALIB_ENABLE: r_calib_en   <= i_cfg_wdata[0];
                CFG_LIMIT_LOW:    r_limit_low  <= i_cfg_wdata[POS_W-1:0];
                CFG_LIMIT_HIGH:   r_limit_high <= i_cfg_wdata[POS_W-1:0];
                CFG_ANGLE_MIN:    r_angle_min  <= i_cfg_wdata[POS_W-1:0];
                CFG_ANGLE_MAX:    r_angle_max  <= i_cfg_wdata[POS_W-1:0];
                CFG_SERVO_MIN:    r_servo_min  <= i_cfg_wdata[POS_W-1:0];
                CFG_SERVO_MAX:    r_servo_max  <= i_cfg_wdata[POS_W-1:0];
                CFG_VEL_ALPHA:    r_vel_alpha  <= i_cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_issued        = r_issued;
        w_mdu_ctrl.start = 1'b0;
        w_mdu_ctrl.op    = MDU_MUL;
        w_mdu_a         = '0;
        w_mdu_b         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire && i_op) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                n_state = (r_calib_en && (w_den != '0)) ? S_MAP_MUL : S_PULSE;
            end
            S_MAP_MUL: begin
                w_mdu_ctrl.op = MDU_MUL;
                w_mdu_a       = MDU_AW'(mag17(w_num_a));
                w_mdu_b       = mag17(w_num_b);
            end
            S_MAP_DIV: begin
                w_mdu_ctrl.op = MDU_DIV;
                w_mdu_a       = w_mdu_res[MDU_AW-1:0];
                w_mdu_b       = mag17(w_den);
            end
            S_PULSE: begin
                n_state = S_RATE_MUL;
            end
            S_RATE_MUL: begin
                w_mdu_ctrl.op = MDU_MUL;
                w_mdu_a       = MDU_AW'(RATE_SCALE);
                w_mdu_b       = mag17(w_diff);
            end
            S_RATE_DIV: begin
                w_mdu_ctrl.op = MDU_DIV;
                w_mdu_a       = w_mdu_res[MDU_AW-1:0];
                w_mdu_b       = MDU_BW'(r_dt);
            end
            S_VEL_NEW: begin
                w_mdu_ctrl.op = MDU_MUL;
                w_mdu_a       = w_mdu_res[MDU_AW-1:0];
                w_mdu_b       = w_alpha;
            end
            S_VEL_OLD: begin
                w_mdu_ctrl.op = MDU_MUL;
                w_mdu_a       = MDU_AW'(mag32(r_last_vel));
                w_mdu_b       = w_alpha_old;
            end
            S_SUM: begin
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // issue once, advance on completion
        if (r_state == S_MAP_MUL || r_state == S_MAP_DIV || r_state == S_RATE_MUL ||
            r_state == S_RATE_DIV || r_state == S_VEL_NEW || r_state == S_VEL_OLD) begin
            w_mdu_ctrl.start = !r_issued;
            n_issued         = 1'b1;
            if (w_mdu_stat.done) begin
                n_issued = 1'b0;
                unique case (r_state)
                    S_MAP_MUL:  n_state = S_MAP_DIV;
                    S_MAP_DIV:  n_state = S_PULSE;
                    S_RATE_MUL: n_state = S_RATE_DIV;
                    S_RATE_DIV: n_state = S_VEL_NEW;
                    S_VEL_NEW:  n_state = S_VEL_OLD;
                    default:    n_state = S_SUM;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= TARGET_RESET;
            r_last_pos <= '0;
            r_last_vel <= '0;
        end else begin
            if (w_in_fire && !i_op) begin
                r_target <= i_target_pos;
            end else if (r_state == S_CLAMP && r_calib_en) begin
                r_target <= w_clamped;
            end
            if (w_load) begin
                r_last_pos <= r_target;
                r_last_vel <= r_vel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && i_op) begin
            r_dt <= (i_tick_dt == '0) ? DT_W'(1) : i_tick_dt;
        end
        if (r_state == S_CLAMP) begin
            r_val <= r_calib_en ? VAL_W'(r_servo_min) : VAL_W'(r_target);
        end else if (r_state == S_MAP_DIV && w_mdu_stat.done) begin
            r_val <= w_q + VAL_W'(r_servo_min);
        end
        if (r_state == S_PULSE) begin
            if (r_val[VAL_W-1]) begin
                r_pulse <= '0;
            end else if (w_pulse_sh > VAL_W'(PULSE_MAX)) begin
                r_pulse <= PULSE_W'(PULSE_MAX);
            end else begin
                r_pulse <= w_pulse_sh[PULSE_W-1:0];
            end
        end
        if (r_state == S_VEL_NEW && w_mdu_stat.done) begin
            r_term_new <= w_diff[DIFF_W-1] ? -w_prod : w_prod;
        end
        if (r_state == S_VEL_OLD && w_mdu_stat.done) begin
            r_term_old <= r_last_vel[VEL_W-1] ? -w_prod : w_prod;
        end
        if (r_state == S_SUM) begin
            r_sum <= r_term_new + r_term_old;
        end
        if (r_state == S_SCALE) begin
            if (w_vel_fits) begin
                r_vel <= w_shr[VEL_W-1:0];
            end else begin
                r_vel <= w_shr[MDU_PW-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_pulse <= r_pulse;
            r_out_pos   <= r_target;
            r_out_vel   <= r_vel;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_pulse_us  = r_out_pulse;
    assign o_position  = r_out_pos;
    assign o_velocity  = r_out_vel;

    `SCMV_ASSERT_NEXT(a_tick_starts, w_in_fire && i_op, r_state == S_CLAMP, "tick did not start")
    `SCMV_ASSERT_NEXT(a_set_target, w_in_fire && !i_op, (r_state == S_IDLE) && (r_target == $past(i_target_pos)), "target not stored")
    `SCMV_ASSERT_NEXT(a_load_result, w_load, o_out_valid && (r_state == S_IDLE), "result not loaded")
    `SCMV_ASSERT_SAME(a_mdu_done_issued, w_mdu_stat.done, r_issued, "mdu done without request")

endmodule

`default_nettype wire
